>>> design/lkv_pkg.sv
package lkv_pkg;

  // Fixed widths of the channel fields and the configuration register.
  localparam int KEY_W    = 32;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 5;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  // Defaults for the top-level parameters.
  localparam int LKV_ENTRIES    = 16;
  localparam int LKV_KEY_BITS   = 32;
  localparam int LKV_VALUE_BITS = 32;

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_FIND   = 1'b1
  } lkv_op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_HIT       = 2'd2,
    ST_MISS      = 2'd3
  } lkv_status_e;

  // Command broadcast from the control logic to every cell.
  typedef struct packed {
    logic go;          // the pending word is resolved at this edge
    logic promote;     // find that hit: the matching entry becomes most recent
    logic insert_new;  // insert of a key not yet present
    logic evict;       // table is at capacity: the oldest entry gives way
  } lkv_cmd_t;

endpackage

>>> design/lkv_req_if.sv
interface lkv_req_if
  import lkv_pkg::*;
();
  logic                valid;
  logic                ready;
  lkv_op_e             opcode;
  logic [KEY_W-1:0]    key;
  logic [VALUE_W-1:0]  value;

  modport source (output valid, output opcode, output key, output value, input ready);
  modport sink   (input valid, input opcode, input key, input value, output ready);
endinterface

>>> design/lkv_rsp_if.sv
interface lkv_rsp_if
  import lkv_pkg::*;
();
  logic                valid;
  logic                ready;
  lkv_status_e         status;
  logic [VALUE_W-1:0]  found_value;

  modport source (output valid, output status, output found_value, input ready);
  modport sink   (input valid, input status, input found_value, output ready);
endinterface

>>> design/lkv_cell.sv
module lkv_cell
  import lkv_pkg::*;
#(
  parameter int KEY_BITS   = LKV_KEY_BITS,
  parameter int VALUE_BITS = LKV_VALUE_BITS,
  parameter int RANK_W     = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lkv_cmd_t              cmd_i,
  input  logic [KEY_BITS-1:0]   key_i,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic [RANK_W-1:0]     hit_rank_i,
  input  logic [RANK_W-1:0]     victim_rank_i,
  // Chain from the lower-index neighbor.
  input  logic                  hit_i,
  input  logic [RANK_W-1:0]     rank_acc_i,
  input  logic [VALUE_BITS-1:0] value_acc_i,
  input  logic                  free_seen_i,
  // Chain to the higher-index neighbor.
  output logic                  hit_o,
  output logic [RANK_W-1:0]     rank_acc_o,
  output logic [VALUE_BITS-1:0] value_acc_o,
  output logic                  free_seen_o
);

  logic                  valid_q, valid_d;
  logic [RANK_W-1:0]     rank_q, rank_d;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] value_q;

  logic match, victim, free_here, take;

  assign match     = valid_q && (key_q == key_i);
  assign victim    = cmd_i.evict && valid_q && (rank_q == victim_rank_i);
  assign free_here = !valid_q || victim;
  assign take      = cmd_i.insert_new && free_here && !free_seen_i;

  // Keys are unique among valid entries, so at most one cell adds to the sums.
  assign hit_o       = hit_i | match;
  assign rank_acc_o  = rank_acc_i | (match ? rank_q : '0);
  assign value_acc_o = value_acc_i | (match ? value_q : '0);
  assign free_seen_o = free_seen_i | free_here;

  always_comb begin
    valid_d = valid_q;
    rank_d  = rank_q;
    if (cmd_i.go && cmd_i.promote) begin
      if (match) begin
        rank_d = '0;
      end else if (valid_q && (rank_q < hit_rank_i)) begin
        rank_d = rank_q + 1'b1;
      end
    end else if (cmd_i.go && cmd_i.insert_new) begin
      if (take) begin
        valid_d = 1'b1;
        rank_d  = '0;
      end else if (victim) begin
        valid_d = 1'b0;
        rank_d  = '0;
      end else if (valid_q) begin
        rank_d = rank_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rank_q  <= '0;
    end else begin
      valid_q <= valid_d;
      rank_q  <= rank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.go && take) begin
      key_q   <= key_i;
      value_q <= value_i;
    end
  end

endmodule

>>> design/lru_key_value_cache_unit.sv
// Fully associative key/value cache with least-recently-used replacement.
// Words arrive on req_i (opcode, key, value) and each one gives exactly one
// word on rsp_o (status, found_value), in order. An insert of a key already
// present returns a duplicate status; otherwise it takes the lowest free entry,
// or replaces the oldest entry when occupancy has reached the capacity set by
// the active_entries register (cfg_we_i / cfg_wdata_i, write only while idle).
// A find returns the stored value and makes the entry most recent.
// An accepted request word is captured in a request register. Once the output
// register is empty or its word is being taken, the row of cells compares its
// key in every entry, ripples hit, rank and free-slot information from cell to
// cell, and updates the ranks where a find hits or a new key is inserted. The
// result is captured in the output register, which drives the response word.
// With the receiver always ready, one word per cycle is sustained.
// If the receiver stalls, the response waits in the output register while the
// next request may still be accepted; that request then waits until the
// output register frees up. Reset empties the table and sets the capacity to
// sixteen entries; no clearing pass is needed.
module lru_key_value_cache_unit
  import lkv_pkg::*;
#(
  parameter int ENTRIES    = LKV_ENTRIES,
  parameter int KEY_BITS   = LKV_KEY_BITS,
  parameter int VALUE_BITS = LKV_VALUE_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  lkv_req_if.sink          req_i,
  lkv_rsp_if.source        rsp_o
);

  localparam int RANK_W = $clog2(ENTRIES);
  localparam int OCC_W  = $clog2(ENTRIES + 1);
  localparam int CMP_W  = (OCC_W > CFG_W) ? OCC_W : CFG_W;

  logic                  busy_q, busy_d;
  lkv_op_e               op_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] value_q;
  logic [OCC_W-1:0]      occ_q, occ_d;
  logic [CFG_W-1:0]      active_q;
  logic                  out_valid_q, out_valid_d;
  lkv_status_e           status_q, status_d;
  logic [VALUE_W-1:0]    found_q, found_d;

  logic                  go, accept;
  logic [CMP_W-1:0]      cfg_ext, cap;
  logic                  at_capacity;
  logic [RANK_W-1:0]     victim_rank;
  lkv_cmd_t              cmd;

  logic                  hit_c       [ENTRIES+1];
  logic [RANK_W-1:0]     rank_c      [ENTRIES+1];
  logic [VALUE_BITS-1:0] value_c     [ENTRIES+1];
  logic                  free_seen_c [ENTRIES+1];

  assign go           = busy_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready  = !busy_q || go;
  assign accept       = req_i.valid && req_i.ready;

  // Capacity is the register value held between one and the table size.
  assign cfg_ext = CMP_W'(active_q);
  always_comb begin
    if (cfg_ext == '0) begin
      cap = CMP_W'(1);
    end else if (cfg_ext > CMP_W'(ENTRIES)) begin
      cap = CMP_W'(ENTRIES);
    end else begin
      cap = cfg_ext;
    end
  end

  assign at_capacity = CMP_W'(occ_q) >= cap;
  // Valid entries hold distinct ranks 0..occupancy-1, so the oldest has the top one.
  assign victim_rank = RANK_W'(occ_q - OCC_W'(1));

  assign cmd.go         = go;
  assign cmd.promote    = (op_q == OP_FIND) && hit_c[ENTRIES];
  assign cmd.insert_new = (op_q == OP_INSERT) && !hit_c[ENTRIES];
  assign cmd.evict      = at_capacity;

  assign hit_c[0]       = 1'b0;
  assign rank_c[0]      = '0;
  assign value_c[0]     = '0;
  assign free_seen_c[0] = 1'b0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lkv_cell #(
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS),
      .RANK_W     (RANK_W)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd),
      .key_i         (key_q),
      .value_i       (value_q),
      .hit_rank_i    (rank_c[ENTRIES]),
      .victim_rank_i (victim_rank),
      .hit_i         (hit_c[g]),
      .rank_acc_i    (rank_c[g]),
      .value_acc_i   (value_c[g]),
      .free_seen_i   (free_seen_c[g]),
      .hit_o         (hit_c[g+1]),
      .rank_acc_o    (rank_c[g+1]),
      .value_acc_o   (value_c[g+1]),
      .free_seen_o   (free_seen_c[g+1])
    );
  end

  always_comb begin
    busy_d = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (go) begin
      busy_d = 1'b0;
    end
  end

  always_comb begin
    occ_d = occ_q;
    if (go && cmd.insert_new && !at_capacity) begin
      occ_d = occ_q + 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (go) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_comb begin
    found_d = '0;
    unique case (op_q)
      OP_FIND: begin
        status_d = hit_c[ENTRIES] ? ST_HIT : ST_MISS;
        if (hit_c[ENTRIES]) begin
          found_d = VALUE_W'(value_c[ENTRIES]);
        end
      end
      OP_INSERT: begin
        status_d = hit_c[ENTRIES] ? ST_DUPLICATE : ST_INSERTED;
      end
      default: begin
        status_d = ST_MISS;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      occ_q       <= '0;
      active_q    <= CFG_RESET;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        active_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= req_i.opcode;
      key_q   <= KEY_BITS'(req_i.key);
      value_q <= VALUE_BITS'(req_i.value);
    end
    if (go) begin
      status_q <= status_d;
      found_q  <= found_d;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.found_value = found_q;

  // The table never holds more entries than it has.
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OCC_W'(ENTRIES))
    else $error("occupancy exceeds table size");

  // An insert of a new key always finds a free or evicted entry.
  a_slot_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go && cmd.insert_new |-> free_seen_c[ENTRIES])
    else $error("insert found no entry to fill");

  // A response word appears only after the row resolved a request.
  a_rsp_from_go: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(go))
    else $error("response without a resolved request");

  // A find that hits is reported as a hit in the next cycle.
  a_hit_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go && cmd.promote |=> status_q == ST_HIT && out_valid_q)
    else $error("find hit not reported");

endmodule

>>> tb/sv/lru_key_value_cache_unit_checker.sv
module lru_key_value_cache_unit_checker
  import lkv_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  lkv_req_if               req_i,
  lkv_rsp_if               rsp_i,
  output int unsigned      error_count_o,
  output int unsigned      pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = LKV_ENTRIES;

  typedef struct packed {
    lkv_status_e        status;
    logic [VALUE_W-1:0] found_value;
  } cache_reply_t;

  logic [SLOTS-1:0]   slot_used;
  logic [KEY_W-1:0]   slot_key   [SLOTS];
  logic [VALUE_W-1:0] slot_value [SLOTS];
  int unsigned        slot_age   [SLOTS];
  int unsigned        fill_count;
  logic [CFG_W-1:0]   capacity;
  cache_reply_t       reply_queue [$];

  function automatic int unsigned effective_capacity();
    if (capacity == 0) begin
      return 1;
    end
    if (capacity > SLOTS) begin
      return SLOTS;
    end
    return capacity;
  endfunction

  // Drops the valid entry with the largest age, i.e. the least recently used one.
  function automatic void drop_oldest();
    int victim;
    victim = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_used[i] && (victim < 0 || slot_age[i] > slot_age[victim])) begin
        victim = i;
      end
    end
    if (victim >= 0) begin
      slot_used[victim] = 1'b0;
      slot_age[victim]  = 0;
      fill_count--;
    end
  endfunction

  function automatic cache_reply_t resolve_request(lkv_op_e op, logic [KEY_W-1:0] key,
                                                   logic [VALUE_W-1:0] value);
    cache_reply_t reply;
    int           hit_slot;
    int           free_slot;
    int unsigned  hit_age;
    hit_slot  = -1;
    free_slot = -1;
    reply.found_value = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_used[i] && slot_key[i] == key && hit_slot < 0) begin
        hit_slot = i;
      end
    end
    if (op == OP_FIND) begin
      if (hit_slot < 0) begin
        reply.status = ST_MISS;
      end else begin
        reply.status      = ST_HIT;
        reply.found_value = slot_value[hit_slot];
        hit_age = slot_age[hit_slot];
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_used[i] && slot_age[i] < hit_age) begin
            slot_age[i]++;
          end
        end
        slot_age[hit_slot] = 0;
      end
      return reply;
    end
    if (hit_slot >= 0) begin
      reply.status = ST_DUPLICATE;
      return reply;
    end
    // A lowered capacity only ever costs one entry per new insert.
    if (fill_count >= effective_capacity()) begin
      drop_oldest();
    end
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!slot_used[i]) begin
        free_slot = i;
      end
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_used[i]) begin
        slot_age[i]++;
      end
    end
    slot_used[free_slot]  = 1'b1;
    slot_key[free_slot]   = key;
    slot_value[free_slot] = value;
    slot_age[free_slot]   = 0;
    fill_count++;
    reply.status = ST_INSERTED;
    return reply;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cache_reply_t want;
    if (!rst_ni) begin
      slot_used  = '0;
      foreach (slot_age[i]) begin
        slot_age[i] = 0;
      end
      fill_count    = 0;
      capacity      = CFG_RESET;
      reply_queue.delete();
      error_count_o = 0;
      pending_o     = 0;
    end else begin
      if (cfg_we_i) begin
        capacity = cfg_wdata_i;
      end
      // The response word accepted here always belongs to an earlier request.
      if (rsp_i.valid && rsp_i.ready) begin
        if (reply_queue.size() == 0) begin
          $display("%0t: response word with nothing expected, status %0d value %h",
                   $time, rsp_i.status, rsp_i.found_value);
          error_count_o++;
        end else begin
          want = reply_queue.pop_front();
          if (rsp_i.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, rsp_i.status);
            error_count_o++;
          end
          if (rsp_i.found_value !== want.found_value) begin
            $display("%0t: found_value expected %h got %h", $time, want.found_value,
                     rsp_i.found_value);
            error_count_o++;
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        reply_queue.push_back(resolve_request(req_i.opcode, req_i.key, req_i.value));
      end
      pending_o = reply_queue.size();
    end
  end

endmodule

>>> tb/sv/lru_key_value_cache_unit_test.sv
module lru_key_value_cache_unit_test;
  import lkv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  int unsigned      error_count;
  int unsigned      words_pending;
  bit               calm_stretch;

  lkv_req_if req_bus ();
  lkv_rsp_if rsp_bus ();

  lru_key_value_cache_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_bus),
    .rsp_o       (rsp_bus)
  );

  lru_key_value_cache_unit_checker scoreboard (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .req_i         (req_bus),
    .rsp_i         (rsp_bus),
    .error_count_o (error_count),
    .pending_o     (words_pending)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #3000000;
    $display("lru_key_value_cache_unit verification failed");
    $finish;
  end

  // Every call starts and ends on a falling edge, so valid is never lowered and
  // raised within one time step.
  task automatic send_word(input lkv_op_e op, input logic [KEY_W-1:0] key,
                           input logic [VALUE_W-1:0] value);
    int unsigned gap;
    gap = calm_stretch ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_bus.valid  <= 1'b1;
    req_bus.opcode <= op;
    req_bus.key    <= key;
    req_bus.value  <= value;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain_words();
    req_bus.valid <= 1'b0;
    @(negedge clk_i);
    while (words_pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_capacity(input logic [CFG_W-1:0] capacity);
    drain_words();
    cfg_we    <= 1'b1;
    cfg_wdata <= capacity;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // Keys come mostly from a small pool sized a little above the capacity, so
  // hits, duplicates and evictions are all frequent.
  task automatic run_random_phase(input logic [CFG_W-1:0] capacity, input int unsigned count);
    logic [KEY_W-1:0] key_pool [32];
    logic [KEY_W-1:0] key;
    int unsigned      span;
    int unsigned      pick;
    lkv_op_e          op;
    set_capacity(capacity);
    foreach (key_pool[i]) begin
      key_pool[i] = $urandom;
    end
    span = (capacity == 0) ? 1 : (capacity > LKV_ENTRIES) ? LKV_ENTRIES : capacity;
    span = span + 1 + $urandom_range(0, 6);
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        calm_stretch = ($urandom_range(0, 3) == 0);
      end
      op   = $urandom_range(0, 1) ? OP_FIND : OP_INSERT;
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        key = $urandom;
      end else if (pick == 4) begin
        key = '0;
      end else if (pick == 5) begin
        key = '1;
      end else begin
        key = key_pool[$urandom_range(0, span - 1)];
      end
      send_word(op, key, $urandom);
    end
    calm_stretch = 1'b0;
  endtask

  initial begin : response_sink
    int unsigned stall;
    rsp_bus.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = calm_stretch ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      rsp_bus.ready <= 1'b1;
      @(posedge clk_i);
      while (!rsp_bus.valid) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  initial begin : stimulus
    logic [CFG_W-1:0] phase_capacity [9];
    phase_capacity = '{5'd31, 5'd1, 5'd4, 5'd0, 5'd16, 5'd2, 5'd8, 5'd17, 5'd12};
    calm_stretch   = 1'b0;
    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    req_bus.valid  = 1'b0;
    req_bus.opcode = OP_INSERT;
    req_bus.key    = '0;
    req_bus.value  = '0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Empty table, reset capacity, extreme keys and values, a duplicate insert.
    send_word(OP_FIND, 32'd5, 32'hDEAD_BEEF);
    send_word(OP_INSERT, '0, '0);
    send_word(OP_INSERT, '1, '1);
    send_word(OP_INSERT, '0, 32'h0000_1234);
    send_word(OP_FIND, '0, '1);
    send_word(OP_FIND, '1, '0);
    for (int k = 1; k <= 4; k++) begin
      send_word(OP_INSERT, k, $urandom);
    end
    send_word(OP_FIND, 32'd1, '0);

    // Capacity lowered below the current occupancy: one eviction per new key.
    set_capacity(5'd2);
    send_word(OP_INSERT, 32'd7, $urandom);
    send_word(OP_INSERT, 32'd8, $urandom);
    send_word(OP_FIND, 32'd7, '0);
    send_word(OP_FIND, 32'd2, '0);

    // A zero capacity behaves as a single entry.
    set_capacity(5'd0);
    send_word(OP_INSERT, 32'd9, $urandom);
    send_word(OP_FIND, 32'd7, '0);
    send_word(OP_FIND, 32'd9, '0);

    // A capacity above the table size is clamped to the table size.
    set_capacity(5'd31);
    send_word(OP_INSERT, 32'd20, $urandom);
    send_word(OP_FIND, 32'd9, '0);

    foreach (phase_capacity[p]) begin
      run_random_phase(phase_capacity[p], 75);
    end

    drain_words();
    if (error_count == 0) begin
      $display("lru_key_value_cache_unit verification clean");
    end else begin
      $display("lru_key_value_cache_unit verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
design/lkv_pkg.sv
design/lkv_req_if.sv
design/lkv_rsp_if.sv
design/lkv_cell.sv
design/lru_key_value_cache_unit.sv
tb/sv/lru_key_value_cache_unit_checker.sv
tb/sv/lru_key_value_cache_unit_test.sv
